### rtl/kmpau_pkg.sv
// Shared types and constants for the 2-D k-means assign/update core.
package kmpau_pkg;

	localparam int COORD_BITS       = 16;
	localparam int IDX_BITS         = 3;
	localparam int SUM_BITS         = 32;
	localparam int COUNT_BITS       = 17;
	localparam int NUM_CLUSTERS_DEF = 8;
	localparam int MAX_POINTS_DEF   = 65536;
	localparam int QUEUE_DEPTH      = 4;
	localparam int IN_DATA_BITS     = 40;
	localparam int OUT_DATA_BITS    = 56;

	localparam logic ACT_SEED    = 1'b0;
	localparam logic ACT_POINT   = 1'b1;
	localparam logic KIND_LABEL  = 1'b0;
	localparam logic KIND_CENTRE = 1'b1;

	typedef struct packed {
		logic                         is_point;
		logic [IDX_BITS-1:0]          idx;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         last;
	} q_entry_t;

endpackage

### rtl/kmeans_point_assign_update_core.sv
// Top level of the 2-D k-means point assign and centre update core.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tuser=action, tlast=last_of_pass, tdata
//  m_axis   | out | m_axis_tvalid/tready    | tuser=kind, tlast=last, tdata
//
// A point takes one distance step over all lanes, then a scan over the centres one per
// cycle, then accumulation and a label step that waits for the output. A seed is
// written while idle. The last point of a pass runs the bit-serial dividers once per
// centre. A four-item queue lets input be taken while the back end works.
// Reset clears centres, sums, counts and the overflow flag at once.
module kmeans_point_assign_update_core import kmpau_pkg::*; #(
	parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
	parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// centre_index[2:0], point_x[18:3], point_y[34:19], zero pad
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// action
	input  logic                     s_axis_tuser,
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// label[2:0], centre_x[18:3], centre_y[34:19], member_count[51:35], overflow[52], pad
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	// kind
	output logic                     m_axis_tuser,
	output logic                     m_axis_tlast
);

	q_entry_t in_entry;
	q_entry_t out_entry;
	logic     push;
	logic     full;
	logic     valid;
	logic     pop;

	kmpau_front #(.NUM_CLUSTERS(NUM_CLUSTERS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (full),
		.q_push        (push),
		.q_entry       (in_entry)
	);

	kmpau_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_entry),
		.full   (full),
		.valid  (valid),
		.dout   (out_entry),
		.pop    (pop)
	);

	kmpau_back #(.NUM_CLUSTERS(NUM_CLUSTERS), .MAX_POINTS(MAX_POINTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (valid),
		.q_entry       (out_entry),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### rtl/kmpau_front.sv
// Input side: accept items, drop out-of-range seeds, push into the queue.
module kmpau_front import kmpau_pkg::*; #(
	parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
	input  logic                    s_axis_tuser,
	input  logic                    s_axis_tlast,
	input  logic                    q_full,
	output logic                    q_push,
	output q_entry_t                q_entry
);

	logic seed_ok;

	assign s_axis_tready = !q_full;
	assign seed_ok = 32'(s_axis_tdata[IDX_BITS-1:0]) < NUM_CLUSTERS;
	assign q_push = s_axis_tvalid && !q_full && (s_axis_tuser == ACT_POINT || seed_ok);

	always_comb begin
		q_entry.is_point = (s_axis_tuser == ACT_POINT);
		q_entry.idx      = s_axis_tdata[IDX_BITS-1:0];
		q_entry.x        = s_axis_tdata[IDX_BITS +: COORD_BITS];
		q_entry.y        = s_axis_tdata[IDX_BITS+COORD_BITS +: COORD_BITS];
		q_entry.last     = s_axis_tlast;
	end

endmodule

### rtl/kmpau_fifo.sv
// Short queue of classified items between front and back.
module kmpau_fifo import kmpau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	output logic     full,
	output logic     valid,
	output q_entry_t dout,
	input  logic     pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/kmpau_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module kmpau_div import kmpau_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_BITS-1:0]   dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  done,
	output logic [COORD_BITS-1:0] quotient
);

	localparam int SW = $clog2(SUM_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [SW-1:0]         step_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic                  neg_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;

	assign trial    = {rem_q, quo_q[SUM_BITS-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = neg_q ? (COORD_BITS'(0) - quo_q[COORD_BITS-1:0]) : quo_q[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(SUM_BITS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_BITS-1];
			quo_q <= dividend[SUM_BITS-1] ? (SUM_BITS'(0) - dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], ge};
		end
	end

endmodule

### rtl/kmpau_back.sv
// Back end: nearest-centre search, accumulation, pass-end means and result register.
module kmpau_back import kmpau_pkg::*; #(
	parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
	parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  q_entry_t                 q_entry,
	output logic                     q_pop,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	output logic                     m_axis_tuser,
	output logic                     m_axis_tlast
);

	localparam int IW = $clog2(NUM_CLUSTERS);
	localparam int TW = $clog2(MAX_POINTS + 1);
	localparam int SQ = 2 * (COORD_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIST, ST_SCAN, ST_ACC, ST_LABEL, ST_DIV, ST_WAIT, ST_EMIT
	} state_t;

	state_t state_q;

	logic signed [COORD_BITS-1:0] cx_q [NUM_CLUSTERS];
	logic signed [COORD_BITS-1:0] cy_q [NUM_CLUSTERS];
	logic [SUM_BITS-1:0]          sumx_q [NUM_CLUSTERS];
	logic [SUM_BITS-1:0]          sumy_q [NUM_CLUSTERS];
	logic [COUNT_BITS-1:0]        cnt_q [NUM_CLUSTERS];
	logic [SQ-1:0]                sqx_q [NUM_CLUSTERS];
	logic [SQ-1:0]                sqy_q [NUM_CLUSTERS];
	logic [SQ-1:0]                sqx_c [NUM_CLUSTERS];
	logic [SQ-1:0]                sqy_c [NUM_CLUSTERS];
	logic [TW-1:0]                total_q;
	logic                         ovf_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic                         last_q;
	logic [IW-1:0]                scan_q;
	logic [IW-1:0]                best_q;
	logic [SQ:0]                  bestd_q;
	logic [SQ:0]                  d_scan;
	logic                         out_v_q;
	logic                         out_kind_q;
	logic [IDX_BITS-1:0]          out_label_q;
	logic [COORD_BITS-1:0]        out_cx_q;
	logic [COORD_BITS-1:0]        out_cy_q;
	logic [COUNT_BITS-1:0]        out_cnt_q;
	logic                         out_ovf_q;
	logic                         out_last_q;
	logic                         free;
	logic                         out_load;
	logic                         div_start;
	logic                         dx_done;
	logic                         dy_done;
	logic [COORD_BITS-1:0]        qx;
	logic [COORD_BITS-1:0]        qy;
	logic [COORD_BITS-1:0]        mx;
	logic [COORD_BITS-1:0]        my;
	logic                         scan_end;

	always_comb begin
		for (int i = 0; i < NUM_CLUSTERS; i++) begin
			logic signed [COORD_BITS:0] ddx;
			logic signed [COORD_BITS:0] ddy;
			logic [COORD_BITS:0]        ax;
			logic [COORD_BITS:0]        ay;
			ddx = {cx_q[i][COORD_BITS-1], cx_q[i]} - {px_q[COORD_BITS-1], px_q};
			ddy = {cy_q[i][COORD_BITS-1], cy_q[i]} - {py_q[COORD_BITS-1], py_q};
			ax = ddx[COORD_BITS] ? (COORD_BITS+1)'(0) - ddx : ddx;
			ay = ddy[COORD_BITS] ? (COORD_BITS+1)'(0) - ddy : ddy;
			sqx_c[i] = SQ'(ax) * SQ'(ax);
			sqy_c[i] = SQ'(ay) * SQ'(ay);
		end
	end

	assign d_scan    = {1'b0, sqx_q[scan_q]} + {1'b0, sqy_q[scan_q]};
	assign free      = !out_v_q || m_axis_tready;
	assign out_load  = free && (state_q == ST_LABEL || state_q == ST_EMIT);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign div_start = (state_q == ST_DIV);
	assign scan_end  = (scan_q == IW'(NUM_CLUSTERS - 1));
	assign mx        = (cnt_q[scan_q] == '0) ? '0 : qx;
	assign my        = (cnt_q[scan_q] == '0) ? '0 : qy;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_ovf_q, out_cnt_q, out_cy_q, out_cx_q, out_label_q};

	kmpau_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sumx_q[scan_q]),
		.divisor  (cnt_q[scan_q]),
		.done     (dx_done),
		.quotient (qx)
	);

	kmpau_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sumy_q[scan_q]),
		.divisor  (cnt_q[scan_q]),
		.done     (dy_done),
		.quotient (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			ovf_q   <= 1'b0;
			total_q <= '0;
			scan_q  <= '0;
			for (int i = 0; i < NUM_CLUSTERS; i++) begin
				cx_q[i]   <= '0;
				cy_q[i]   <= '0;
				sumx_q[i] <= '0;
				sumy_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (!q_entry.is_point) begin
							cx_q[IW'(q_entry.idx)] <= q_entry.x;
							cy_q[IW'(q_entry.idx)] <= q_entry.y;
						end else begin
							px_q    <= q_entry.x;
							py_q    <= q_entry.y;
							last_q  <= q_entry.last;
							state_q <= ST_DIST;
						end
					end
				end
				ST_DIST: begin
					for (int i = 0; i < NUM_CLUSTERS; i++) begin
						sqx_q[i] <= sqx_c[i];
						sqy_q[i] <= sqy_c[i];
					end
					scan_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q == '0 || d_scan < bestd_q) begin
						bestd_q <= d_scan;
						best_q  <= scan_q;
					end
					if (scan_end) begin
						state_q <= ST_ACC;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_ACC: begin
					if (total_q >= TW'(MAX_POINTS)) begin
						ovf_q <= 1'b1;
					end else begin
						sumx_q[best_q] <= sumx_q[best_q] + SUM_BITS'(px_q);
						sumy_q[best_q] <= sumy_q[best_q] + SUM_BITS'(py_q);
						cnt_q[best_q]  <= cnt_q[best_q] + 1'b1;
						total_q        <= total_q + 1'b1;
					end
					state_q <= ST_LABEL;
				end
				ST_LABEL: begin
					if (free) begin
						out_kind_q  <= KIND_LABEL;
						out_label_q <= IDX_BITS'(best_q);
						out_cx_q    <= '0;
						out_cy_q    <= '0;
						out_cnt_q   <= cnt_q[best_q];
						out_ovf_q   <= ovf_q;
						out_last_q  <= !last_q;
						scan_q      <= '0;
						state_q     <= last_q ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (dx_done && dy_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (free) begin
						out_kind_q   <= KIND_CENTRE;
						out_label_q  <= IDX_BITS'(scan_q);
						out_cx_q     <= mx;
						out_cy_q     <= my;
						out_cnt_q    <= cnt_q[scan_q];
						out_ovf_q    <= ovf_q;
						out_last_q   <= scan_end;
						cx_q[scan_q] <= mx;
						cy_q[scan_q] <= my;
						if (scan_end) begin
							for (int i = 0; i < NUM_CLUSTERS; i++) begin
								sumx_q[i] <= '0;
								sumy_q[i] <= '0;
								cnt_q[i]  <= '0;
							end
							total_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/kmpau_checker.sv
// Port-level checks for the k-means core, bound to the top level.
module kmpau_checker import kmpau_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input logic                     m_axis_tuser,
	input logic                     m_axis_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_label_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_LABEL |-> m_axis_tdata[34:3] == '0)
		else $error("label item carries centre coordinates");

	a_empty_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_CENTRE && m_axis_tdata[51:35] == '0
		|-> m_axis_tdata[34:3] == '0)
		else $error("empty cluster centre not at origin");

endmodule

bind kmeans_point_assign_update_core kmpau_checker u_kmpau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

### tb/sv/kmeans_result_checker.sv
`timescale 1ns / 100ps
// Checker for the k-means core: predicts labels and centre updates and compares each result item.
module kmeans_result_checker import kmpau_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	input  logic                     s_axis_tuser,
	input  logic                     s_axis_tlast,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input  logic                     m_axis_tuser,
	input  logic                     m_axis_tlast,
	output int                       fail_count,
	output int                       pending
);

	localparam int NC = NUM_CLUSTERS_DEF;

	typedef struct packed {
		logic                    kind;
		logic [OUT_DATA_BITS-1:0] data;
		logic                    last;
	} km_result_t;

	km_result_t expected_results[$];
	logic signed [15:0] cen_x [NC];
	logic signed [15:0] cen_y [NC];
	logic [31:0] sum_x [NC];
	logic [31:0] sum_y [NC];
	logic [16:0] cnt [NC];
	logic ovf;

	assign pending = expected_results.size();

	function automatic logic [OUT_DATA_BITS-1:0] pack_result(logic [2:0] lbl,
			logic [15:0] cx, logic [15:0] cy, logic [16:0] mc, logic of);
		logic [OUT_DATA_BITS-1:0] d;
		d = '0;
		d[2:0] = lbl;
		d[18:3] = cx;
		d[34:19] = cy;
		d[51:35] = mc;
		d[52] = of;
		return d;
	endfunction

	task automatic assign_and_update(logic act, logic [IN_DATA_BITS-1:0] td, logic endp);
		logic [2:0] idx;
		logic signed [15:0] px, py;
		longint dx, dy, sq_dist, best_dist, total, q;
		int best;
		km_result_t r;
		idx = td[2:0];
		px = td[18:3];
		py = td[34:19];
		if (act == ACT_SEED) begin
			cen_x[idx] = px;
			cen_y[idx] = py;
			return;
		end
		best = 0;
		best_dist = 0;
		for (int i = 0; i < NC; i++) begin
			dx = longint'(cen_x[i]) - longint'(px);
			dy = longint'(cen_y[i]) - longint'(py);
			sq_dist = dx * dx + dy * dy;
			if (i == 0 || sq_dist < best_dist) begin
				best_dist = sq_dist;
				best = i;
			end
		end
		total = 0;
		for (int i = 0; i < NC; i++)
			total += cnt[i];
		if (total >= MAX_POINTS_DEF) begin
			ovf = 1'b1;
		end else begin
			sum_x[best] += {{16{px[15]}}, px};
			sum_y[best] += {{16{py[15]}}, py};
			cnt[best] = cnt[best] + 17'd1;
		end
		r.kind = KIND_LABEL;
		r.data = pack_result(best[2:0], '0, '0, cnt[best], ovf);
		r.last = !endp;
		expected_results.insert(expected_results.size(), r);
		if (!endp)
			return;
		for (int i = 0; i < NC; i++) begin
			logic [15:0] mx, my;
			mx = '0;
			my = '0;
			if (cnt[i] != 0) begin
				q = longint'($signed(sum_x[i])) / longint'(cnt[i]);
				mx = q[15:0];
				q = longint'($signed(sum_y[i])) / longint'(cnt[i]);
				my = q[15:0];
			end
			cen_x[i] = mx;
			cen_y[i] = my;
			r.kind = KIND_CENTRE;
			r.data = pack_result(i[2:0], mx, my, cnt[i], ovf);
			r.last = (i == NC - 1);
			expected_results.insert(expected_results.size(), r);
		end
		for (int i = 0; i < NC; i++) begin
			sum_x[i] = '0;
			sum_y[i] = '0;
			cnt[i] = '0;
		end
		ovf = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			expected_results.delete();
			for (int i = 0; i < NC; i++) begin
				cen_x[i] = '0;
				cen_y[i] = '0;
				sum_x[i] = '0;
				sum_y[i] = '0;
				cnt[i] = '0;
			end
			ovf = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				km_result_t got, exp_r;
				got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected kind=%b data=%h last=%b actual kind=%b data=%h last=%b",
							$time, exp_r.kind, exp_r.data, exp_r.last,
							got.kind, got.data, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				assign_and_update(s_axis_tuser, s_axis_tdata, s_axis_tlast);
		end
	end

endmodule

### tb/sv/tb_kmeans_point_assign_update_core.sv
`timescale 1ns / 100ps
// Testbench top for the k-means core: drives seeds and point passes, gives the verdict.
module tb_kmeans_point_assign_update_core;
	import kmpau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	int fail_count;
	int pending;
	bit calm = 1'b0;

	always #5 clk = ~clk;

	kmeans_point_assign_update_core dut (.*);

	kmeans_result_checker checker_i (.*);

	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 8);

	task automatic send_item(logic act, logic [2:0] idx, logic [15:0] x, logic [15:0] y,
			logic endp);
		logic [IN_DATA_BITS-1:0] d;
		while (!calm && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		d = '0;
		d[2:0] = idx;
		d[18:3] = x;
		d[34:19] = y;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= d;
		s_axis_tlast <= endp;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(40)) - 16'd20;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int npts;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, ties, empty clusters, seeds with last set
		send_item(ACT_POINT, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(ACT_SEED, 3'd7, 16'h7fff, 16'h7fff, 1'b1);
		send_item(ACT_SEED, 3'd6, 16'h8000, 16'h8000, 1'b0);
		send_item(ACT_SEED, 3'd1, 16'd10, 16'd0, 1'b0);
		send_item(ACT_SEED, 3'd2, 16'hfff6, 16'd0, 1'b0);
		send_item(ACT_POINT, 3'd7, 16'h7fff, 16'h7fff, 1'b0);
		send_item(ACT_POINT, 3'd0, 16'h8000, 16'h8000, 1'b0);
		send_item(ACT_POINT, 3'd0, 16'h8000, 16'h7fff, 1'b0);
		send_item(ACT_POINT, 3'd0, 16'd5, 16'd0, 1'b0);
		send_item(ACT_POINT, 3'd0, 16'hfffb, 16'd0, 1'b0);
		send_item(ACT_POINT, 3'd0, 16'hfff0, 16'd3, 1'b0);
		send_item(ACT_POINT, 3'd0, 16'hfff1, 16'hfffd, 1'b1);
		send_item(ACT_POINT, 3'd5, 16'h7fff, 16'h8000, 1'b1);
		calm = 1'b1;
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 8; i++)
				send_item(ACT_SEED, 3'(i), rand_coord(), rand_coord(), 1'($urandom));
			npts = $urandom_range(12, 3);
			for (int i = 0; i < npts; i++)
				send_item(ACT_POINT, 3'($urandom), rand_coord(), rand_coord(), i == npts - 1);
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		for (int n = 0; n < 110; ) begin
			if ($urandom_range(3) == 0) begin
				send_item(ACT_SEED, 3'($urandom), rand_coord(), rand_coord(), 1'($urandom));
			end else begin
				send_item(ACT_POINT, 3'($urandom), rand_coord(), rand_coord(),
					$urandom_range(9) == 0);
			end
			n++;
		end
		send_item(ACT_POINT, 3'd0, rand_coord(), rand_coord(), 1'b1);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
